/* src/rpuf_pkg.sv */
`default_nettype none
package rpuf_pkg;

  // config register
  localparam int RW_W = 10;
  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 10'd320;

  // png filter type up
  localparam logic [7:0] UP_TYPE_BYTE = 8'd2;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef enum logic [1:0] {
    KIND_FILTER = 2'd0,
    KIND_RED    = 2'd1,
    KIND_GREEN  = 2'd2,
    KIND_BLUE   = 2'd3
  } byte_kind_t;

  // one classified pixel, ready to serialize
  typedef struct packed {
    logic [7:0] diff_r;
    logic [7:0] diff_g;
    logic [7:0] diff_b;
    logic       row_start;
    logic       row_end;
  } pix_item_t;

endpackage
`default_nettype wire

/* src/rgb565_png_up_filter_unit.sv */
`default_nettype none
// channel   direction  handshake          beat contents
// in_       input      in_push / in_full  in_pixel, in_frame_start
// out_      output     out_pop / out_empty out_data_byte, out_byte_kind,
//                                          out_row_end, out_last
// cfg_      input      cfg_wr_en          cfg_wr_data (row width)
//
// each pixel gives 4 output beats at row start, 3 otherwise; the byte
// serializer emits one beat per cycle while out_pop takes each beat.
// the first beat of a pixel reaches out_ through the line store read, the
// queue write and the output reg, in that order.
// a 4-entry queue decouples pixel intake from the serializer; in_full rises
// when it and the beat in flight fill it. reset clears position and queue;
// the line store needs no clearing, the first row reads as zero.
module rgb565_png_up_filter_unit import rpuf_pkg::*; #(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     in_pixel,
  input  wire logic            in_frame_start,
  input  wire logic            in_push,
  output logic                 in_full,
  output logic [7:0]           out_data_byte,
  output logic [1:0]           out_byte_kind,
  output logic                 out_row_end,
  output logic                 out_last,
  output logic                 out_empty,
  input  wire logic            out_pop,
  input  wire logic            cfg_wr_en,
  input  wire logic [RW_W-1:0] cfg_wr_data
);

  logic [RW_W-1:0] row_width_r;
  logic [QCW-1:0]  q_count;
  logic            q_push, q_pop, q_empty;
  pix_item_t       q_item, q_head;

  // row width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width_r <= cfg_wr_data;
    end
  end

  rpuf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .in_push       (in_push),
    .in_full       (in_full),
    .row_width     (row_width_r),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_item        (q_item)
  );

  rpuf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_item),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  rpuf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_data_byte(out_data_byte),
    .out_byte_kind(out_byte_kind),
    .out_row_end  (out_row_end),
    .out_last     (out_last),
    .out_empty    (out_empty),
    .out_pop      (out_pop)
  );

endmodule
`default_nettype wire

/* src/rpuf_ram.sv */
`default_nettype none
module rpuf_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* src/rpuf_front.sv */
`default_nettype none
module rpuf_front import rpuf_pkg::*; #(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     in_pixel,
  input  wire logic            in_frame_start,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire logic [RW_W-1:0] row_width,
  input  wire logic [QCW-1:0]  q_count,
  output logic                 q_push,
  output pix_item_t            q_item
);

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = ((AW + 1 > RW_W) ? AW + 1 : RW_W) + 1;

  logic [AW-1:0]   column_r, column_nxt;
  logic            first_r, first_nxt;
  logic            accept;
  logic [AW-1:0]   col_cur;
  logic            first_cur;
  logic [CMPW-1:0] w_raw, w_eff;
  logic            rend;
  logic [23:0]     rgb;
  logic [23:0]     above_raw, above;

  logic            s1_valid_r;
  logic [23:0]     s1_rgb_r;
  logic            s1_first_r;
  logic            s1_start_r;
  logic            s1_rend_r;

  // room check counts the beat still in flight to the queue
  assign in_full = (QCW'(q_count + QCW'(s1_valid_r)) >= QCW'(QDEPTH));
  assign accept  = in_push & ~in_full;

  // position in row, a frame start restarts it
  assign col_cur   = in_frame_start ? '0 : column_r;
  assign first_cur = in_frame_start | first_r;

  // effective row width, clamped to 1..MAX_WIDTH
  always_comb begin
    w_raw = CMPW'(row_width);
    if (w_raw == '0) begin
      w_eff = CMPW'(1);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  assign rend = ((CMPW'(col_cur) + CMPW'(1)) >= w_eff);

  // rgb565 to rgb888 by bit replication
  assign rgb = {in_pixel[15:11], in_pixel[15:13],
                in_pixel[10:5],  in_pixel[10:9],
                in_pixel[4:0],   in_pixel[4:2]};

  // row position update
  always_comb begin
    column_nxt = column_r;
    first_nxt  = first_r;
    if (accept) begin
      if (rend) begin
        column_nxt = '0;
        first_nxt  = 1'b0;
      end else begin
        column_nxt = col_cur + AW'(1);
        first_nxt  = first_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      column_r   <= column_nxt;
      first_r    <= first_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rgb_r   <= rgb;
      s1_first_r <= first_cur;
      s1_start_r <= (col_cur == '0);
      s1_rend_r  <= rend;
    end
  end

  // line store: read the pixel above, overwrite it with this one
  rpuf_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH),
    .ADDR_W(AW)
  ) u_line (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(col_cur),
    .wr_data(rgb),
    .rd_addr(col_cur),
    .rd_data(above_raw)
  );

  // up filter, row above is zero on the first row
  assign above = s1_first_r ? 24'd0 : above_raw;

  always_comb begin
    q_push           = s1_valid_r;
    q_item.diff_r    = s1_rgb_r[23:16] - above[23:16];
    q_item.diff_g    = s1_rgb_r[15:8]  - above[15:8];
    q_item.diff_b    = s1_rgb_r[7:0]   - above[7:0];
    q_item.row_start = s1_start_r;
    q_item.row_end   = s1_rend_r;
  end

endmodule
`default_nettype wire

/* src/rpuf_queue.sv */
`default_nettype none
module rpuf_queue import rpuf_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pix_item_t      push_item,
  input  wire logic           pop,
  output pix_item_t           head,
  output logic                empty,
  output logic [QCW-1:0]      count
);

  pix_item_t          entries_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]     count_r;
  logic               do_pop;

  assign empty  = (count_r == '0);
  assign count  = count_r;
  assign head   = entries_r[rd_ptr_r];
  assign do_pop = pop & ~empty;

  // pointers and fill count; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_r + QCW'(push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/rpuf_back.sv */
`default_nettype none
module rpuf_back import rpuf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pix_item_t  head,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_byte_kind,
  output logic            out_row_end,
  output logic            out_last,
  output logic            out_empty,
  input  wire logic       out_pop
);

  byte_kind_t  phase_r, phase_nxt;
  byte_kind_t  kind_cur;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  byte_kind_t  kind_r;
  logic        row_end_r, last_r;
  logic        load;
  logic [7:0]  byte_cur;
  logic        row_end_cur, last_cur;

  // output register frees when empty or taken this beat
  assign load = ~q_empty & (~out_valid_r | (out_pop & out_valid_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= KIND_FILTER;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // byte sequencer: filter byte only at row start, then r, g, b
  always_comb begin
    kind_cur = phase_r;
    if (phase_r == KIND_FILTER && !head.row_start) begin
      kind_cur = KIND_RED;
    end
    byte_cur    = UP_TYPE_BYTE;
    row_end_cur = 1'b0;
    last_cur    = 1'b0;
    phase_nxt   = phase_r;
    case (kind_cur)
      KIND_FILTER: begin
        byte_cur = UP_TYPE_BYTE;
        if (load) phase_nxt = KIND_RED;
      end
      KIND_RED: begin
        byte_cur = head.diff_r;
        if (load) phase_nxt = KIND_GREEN;
      end
      KIND_GREEN: begin
        byte_cur = head.diff_g;
        if (load) phase_nxt = KIND_BLUE;
      end
      KIND_BLUE: begin
        byte_cur    = head.diff_b;
        row_end_cur = head.row_end;
        last_cur    = 1'b1;
        if (load) phase_nxt = KIND_FILTER;
      end
      default: begin
        phase_nxt = KIND_FILTER;
      end
    endcase
    q_pop = load & (kind_cur == KIND_BLUE);
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_cur;
      kind_r    <= kind_cur;
      row_end_r <= row_end_cur;
      last_r    <= last_cur;
    end
  end

  assign out_empty     = ~out_valid_r;
  assign out_data_byte = byte_r;
  assign out_byte_kind = kind_r;
  assign out_row_end   = row_end_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb import rpuf_pkg::*;;

  localparam int LINE_DEPTH  = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // expected byte stream for the up filter, fed by accepted pixels
  class filter_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      byte_kind_t kind;
      logic       row_end;
      logic       last;
    } beat_t;

    beat_t           pending[$];
    logic [23:0]     line_store[LINE_DEPTH];
    bit              written[LINE_DEPTH];
    int unsigned     column;
    bit              first_row;
    logic [RW_W-1:0] width_reg;
    int              errors;

    function new();
      column    = 0;
      first_row = 1'b1;
      width_reg = ROW_WIDTH_RESET;
      errors    = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_width(logic [RW_W-1:0] w);
      width_reg = w;
    endfunction

    // true when the next pixel would read a line store entry never filled
    function bit needs_frame_start();
      return !first_row && !written[column % LINE_DEPTH];
    endfunction

    function void note_pixel(logic [15:0] px, logic fs);
      int unsigned w;
      logic [7:0]  r, g, b, dr, dg, db;
      logic [23:0] above;
      logic        rend;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (fs) begin
        column    = 0;
        first_row = 1'b1;
      end
      if (column >= LINE_DEPTH) column = 0;
      if (column == 0) pending.push_back('{UP_TYPE_BYTE, KIND_FILTER, 1'b0, 1'b0});
      // widen 565 to 888 by bit replication
      r = {px[15:11], px[15:13]};
      g = {px[10:5], px[10:9]};
      b = {px[4:0], px[4:2]};
      above = (first_row || !written[column]) ? 24'd0 : line_store[column];
      line_store[column] = {r, g, b};
      written[column]    = 1'b1;
      dr   = r - above[23:16];
      dg   = g - above[15:8];
      db   = b - above[7:0];
      rend = (column + 1 >= w);
      pending.push_back('{dr, KIND_RED, 1'b0, 1'b0});
      pending.push_back('{dg, KIND_GREEN, 1'b0, 1'b0});
      pending.push_back('{db, KIND_BLUE, rend, 1'b1});
      if (rend) begin
        column    = 0;
        first_row = 1'b0;
      end else begin
        column++;
      end
    endfunction

    function void check_beat(logic [7:0] data, logic [1:0] kind, logic rend, logic fin);
      beat_t exp_beat;
      if (pending.size() == 0) begin
        $error("unexpected beat: data_byte %0h byte_kind %0d", data, kind);
        errors++;
        return;
      end
      exp_beat = pending.pop_front();
      if (data !== exp_beat.data) begin
        $error("data_byte expected %0h actual %0h", exp_beat.data, data);
        errors++;
      end
      if (kind !== exp_beat.kind) begin
        $error("byte_kind expected %0d actual %0d", exp_beat.kind, kind);
        errors++;
      end
      if (rend !== exp_beat.row_end) begin
        $error("row_end expected %0b actual %0b", exp_beat.row_end, rend);
        errors++;
      end
      if (fin !== exp_beat.last) begin
        $error("last expected %0b actual %0b", exp_beat.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic [15:0]     in_pixel;
  logic            in_frame_start;
  logic            in_push;
  logic            in_full;
  logic [7:0]      out_data_byte;
  logic [1:0]      out_byte_kind;
  logic            out_row_end;
  logic            out_last;
  logic            out_empty;
  logic            out_pop;
  logic            cfg_wr_en;
  logic [RW_W-1:0] cfg_wr_data;

  filter_scoreboard sb = new();
  bit               calm;
  bit               hold_req;
  int unsigned      cycles;

  rgb565_png_up_filter_unit #(.MAX_WIDTH(LINE_DEPTH)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .in_push       (in_push),
    .in_full       (in_full),
    .out_data_byte (out_data_byte),
    .out_byte_kind (out_byte_kind),
    .out_row_end   (out_row_end),
    .out_last      (out_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random pop stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        sb.check_beat(out_data_byte, out_byte_kind, out_row_end, out_last);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= rst_n && (calm || $urandom_range(99) >= 13);
      end
    end
  end

  // offer one pixel beat, with random gaps, until accepted
  task automatic send_pixel(input logic [15:0] px, input logic fs);
    logic fs_eff;
    fs_eff = fs | sb.needs_frame_start();
    while (!calm && $urandom_range(99) < 13) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_pixel       <= px;
    in_frame_start <= fs_eff;
    in_push        <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_pixel(px, fs_eff);
  endtask

  // stop offering and wait until every expected beat has come out
  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // row width write, only with the block drained
  task automatic write_width(input logic [RW_W-1:0] w);
    drain();
    cfg_wr_data <= w;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_width(w);
  endtask

  task automatic random_pixels(input int count);
    logic [15:0] px;
    logic [15:0] corner[5] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
    for (int i = 0; i < count; i++) begin
      px = ($urandom_range(7) == 0) ? corner[$urandom_range(4)] : 16'($urandom);
      send_pixel(px, $urandom_range(31) == 0);
    end
  endtask

  // stimulus
  initial begin
    logic [RW_W-1:0] widths[10] = '{10'd3, 10'd1, 10'd1023, 10'd5, 10'd0,
                                    10'd512, 10'd7, 10'd2, 10'd600, 10'd4};
    calm            = 1'b0;
    hold_req        = 1'b0;
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_pixel       <= '0;
    in_frame_start <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width, first row reads as zero, frame start mid-row
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h8410, 1'b1);

    // two-pixel rows: diffs against the row above, channel extremes
    write_width(10'd2);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'hFFFF, 1'b0);

    // width lowered below the current column ends the row at once
    write_width(10'd4);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hABCD, 1'b0);
    send_pixel(16'h5A5A, 1'b0);
    write_width(10'd2);
    send_pixel(16'h0F0F, 1'b0);
    send_pixel(16'hFFFF, 1'b0);

    // zero width acts as one, oversize width clamps
    write_width(10'd0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h0020, 1'b0);
    write_width(10'd1023);
    send_pixel(16'h0400, 1'b1);
    send_pixel(16'hFFFE, 1'b0);

    // random phases over a spread of widths
    for (int p = 0; p < 10; p++) begin
      write_width((p == 9) ? RW_W'($urandom_range(1, 16)) : widths[p]);
      calm = (p == 6);
      if (p == 3) hold_req = 1'b1;
      random_pixels(30);
    end
    calm = 1'b0;

    drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
